// ===== rtl/bba_pkg.sv =====
// Shared constants, types and helper functions of the buddy block allocator.
// Used by every module under rtl except bba_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

	localparam int NUM_PAGES      = 16;
	localparam int LEVEL_COUNT    = 8;
	localparam int MIN_SHIFT      = 5;
	localparam int HEADER_BYTES   = 24;

	localparam int TOP_LEVEL      = LEVEL_COUNT - 1;
	localparam int UNITS_PER_PAGE = 1 << TOP_LEVEL;
	localparam int UNIT_COUNT     = NUM_PAGES * UNITS_PER_PAGE;

	localparam int UNIT_W    = $clog2(UNIT_COUNT);
	localparam int LINK_W    = $clog2(UNIT_COUNT + 1);
	localparam int LVL_W     = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
	localparam int PAGE_W    = $clog2(NUM_PAGES + 1);
	localparam int SIZE_W    = 12;
	localparam int ADDR_W    = 16;
	localparam int BYTES_W   = 17;
	localparam int STATUS_W  = 3;
	localparam int LIMIT_W   = 5;
	localparam int OUT_LVL_W = 3;

	// null link: one past the last unit
	localparam logic [LINK_W-1:0]  NIL         = LINK_W'(UNIT_COUNT);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_ZERO,
		ST_BIG,
		ST_FULL,
		ST_IGNORED
	} status_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DECODE,
		CMD_UNLINK_HEAD1,
		CMD_UNLINK_HEAD2,
		CMD_SPLIT_PUSH,
		CMD_PUSH_LINK,
		CMD_ALLOC_FIN,
		CMD_FREE_CHECK,
		CMD_MERGE_READ,
		CMD_MERGE_UNLINK1,
		CMD_MERGE_UNLINK2,
		CMD_FREE_PUSH,
		CMD_RESP
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_UL1,
		S_UL2,
		S_SPLIT,
		S_PUSH2,
		S_FREE_CHK,
		S_MERGE,
		S_M_TEST,
		S_M_UL2,
		S_RESP
	} state_t;

	typedef struct packed {
		logic is_free;
		logic dec_err;
		logic dec_found;
		logic free_taken;
		logic split_more;
		logic at_top;
		logic bud_free;
		logic out_busy;
	} dp_status_t;

	function automatic logic [BYTES_W-1:0] blk_bytes(input logic [LVL_W-1:0] l);
		return BYTES_W'(33'd1 << (32'(l) + MIN_SHIFT));
	endfunction

	// out-of-range level codes read as the top level
	function automatic logic [LVL_W-1:0] lv_fix(input logic [LVL_W-1:0] l);
		return (32'(l) < LEVEL_COUNT) ? l : LVL_W'(TOP_LEVEL);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bba_ctrl.sv =====
// Sequencer of the buddy block allocator: walks each request through its steps.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bba_pkg::dp_status_t st,
	output bba_pkg::cmd_t           cmd
);

	bba_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bba_pkg::S_IDLE: begin
				if (in_valid) state_d = bba_pkg::S_DECODE;
			end
			bba_pkg::S_DECODE: begin
				if (st.dec_err)        state_d = bba_pkg::S_RESP;
				else if (st.is_free)   state_d = bba_pkg::S_FREE_CHK;
				else if (st.dec_found) state_d = bba_pkg::S_UL1;
				else                   state_d = bba_pkg::S_SPLIT;
			end
			bba_pkg::S_UL1:   state_d = bba_pkg::S_UL2;
			bba_pkg::S_UL2:   state_d = bba_pkg::S_SPLIT;
			bba_pkg::S_SPLIT: begin
				state_d = st.split_more ? bba_pkg::S_PUSH2 : bba_pkg::S_RESP;
			end
			bba_pkg::S_PUSH2: begin
				state_d = st.is_free ? bba_pkg::S_RESP : bba_pkg::S_SPLIT;
			end
			bba_pkg::S_FREE_CHK: begin
				state_d = st.free_taken ? bba_pkg::S_MERGE : bba_pkg::S_RESP;
			end
			bba_pkg::S_MERGE: begin
				state_d = st.at_top ? bba_pkg::S_PUSH2 : bba_pkg::S_M_TEST;
			end
			bba_pkg::S_M_TEST: begin
				state_d = st.bud_free ? bba_pkg::S_M_UL2 : bba_pkg::S_PUSH2;
			end
			bba_pkg::S_M_UL2: state_d = bba_pkg::S_MERGE;
			bba_pkg::S_RESP: begin
				if (!st.out_busy) state_d = bba_pkg::S_IDLE;
			end
			default: state_d = bba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = bba_pkg::CMD_NONE;
		in_ready = 1'b0;
		case (state_q)
			bba_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd = bba_pkg::CMD_LOAD;
			end
			bba_pkg::S_DECODE: cmd = bba_pkg::CMD_DECODE;
			bba_pkg::S_UL1:    cmd = bba_pkg::CMD_UNLINK_HEAD1;
			bba_pkg::S_UL2:    cmd = bba_pkg::CMD_UNLINK_HEAD2;
			bba_pkg::S_SPLIT: begin
				cmd = st.split_more ? bba_pkg::CMD_SPLIT_PUSH : bba_pkg::CMD_ALLOC_FIN;
			end
			bba_pkg::S_PUSH2:    cmd = bba_pkg::CMD_PUSH_LINK;
			bba_pkg::S_FREE_CHK: cmd = bba_pkg::CMD_FREE_CHECK;
			bba_pkg::S_MERGE: begin
				cmd = st.at_top ? bba_pkg::CMD_FREE_PUSH : bba_pkg::CMD_MERGE_READ;
			end
			bba_pkg::S_M_TEST: begin
				cmd = st.bud_free ? bba_pkg::CMD_MERGE_UNLINK1 : bba_pkg::CMD_FREE_PUSH;
			end
			bba_pkg::S_M_UL2: cmd = bba_pkg::CMD_MERGE_UNLINK2;
			bba_pkg::S_RESP: begin
				if (!st.out_busy) cmd = bba_pkg::CMD_RESP;
			end
			default: cmd = bba_pkg::CMD_NONE;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/bba_datapath.sv =====
// Datapath of the buddy block allocator: unit header RAMs, list heads, counters
// and the result register. Depends on bba_pkg and bba_ram.
`timescale 1ns / 1ps
`default_nettype none

module bba_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire bba_pkg::cmd_t                   cmd,
	output bba_pkg::dp_status_t                  st,
	input  wire logic                            func,
	input  wire logic [bba_pkg::SIZE_W-1:0]      alloc_size,
	input  wire logic [bba_pkg::ADDR_W-1:0]      block_address,
	input  wire logic                            cfg_we,
	input  wire logic [bba_pkg::LIMIT_W-1:0]     cfg_wdata,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [bba_pkg::STATUS_W-1:0]    status,
	output logic      [bba_pkg::ADDR_W-1:0]      user_address,
	output logic      [bba_pkg::OUT_LVL_W-1:0]   block_level,
	output logic      [bba_pkg::BYTES_W-1:0]     bytes_given
);

	localparam int UW = bba_pkg::UNIT_W;
	localparam int KW = bba_pkg::LINK_W;
	localparam int LW = bba_pkg::LVL_W;

	// request and working registers
	logic                         func_q;
	logic [bba_pkg::SIZE_W-1:0]   size_q;
	logic [bba_pkg::ADDR_W-1:0]   addr_q;
	logic [UW-1:0]                u_q, half_q, bud_q;
	logic [LW-1:0]                l_q, want_q;
	logic [KW-1:0]                first_q;
	bba_pkg::status_t             res_status_q;
	logic [bba_pkg::ADDR_W-1:0]   res_addr_q;
	logic [LW-1:0]                res_lvl_q;
	logic [KW-1:0]                heads_q [bba_pkg::LEVEL_COUNT];
	logic [bba_pkg::PAGE_W-1:0]   pages_q;
	logic [bba_pkg::BYTES_W-1:0]  bytes_q;
	logic [bba_pkg::LIMIT_W-1:0]  limit_q;
	logic                         out_valid_q;
	bba_pkg::status_t             out_status_q;
	logic [bba_pkg::ADDR_W-1:0]   out_addr_q;
	logic [LW-1:0]                out_lvl_q;
	logic [bba_pkg::BYTES_W-1:0]  out_bytes_q;

	// RAM ports
	logic          tk_we, tk_re, tk_wd, tk_rd;
	logic [UW-1:0] tk_wa, tk_ra;
	logic          lv_we, lv_re;
	logic [UW-1:0] lv_wa, lv_ra;
	logic [LW-1:0] lv_wd, lv_rd;
	logic          nx_we, nx_re;
	logic [UW-1:0] nx_wa, nx_ra;
	logic [KW-1:0] nx_wd, nx_rd;
	logic          pv_we, pv_re;
	logic [UW-1:0] pv_wa, pv_ra;
	logic [KW-1:0] pv_wd, pv_rd;

	bba_ram #(.WIDTH(1), .DEPTH(bba_pkg::UNIT_COUNT)) u_taken (
		.clk(clk), .we(tk_we), .waddr(tk_wa), .wdata(tk_wd),
		.re(tk_re), .raddr(tk_ra), .rdata(tk_rd)
	);
	bba_ram #(.WIDTH(LW), .DEPTH(bba_pkg::UNIT_COUNT)) u_level (
		.clk(clk), .we(lv_we), .waddr(lv_wa), .wdata(lv_wd),
		.re(lv_re), .raddr(lv_ra), .rdata(lv_rd)
	);
	bba_ram #(.WIDTH(KW), .DEPTH(bba_pkg::UNIT_COUNT)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
		.re(nx_re), .raddr(nx_ra), .rdata(nx_rd)
	);
	bba_ram #(.WIDTH(KW), .DEPTH(bba_pkg::UNIT_COUNT)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
		.re(pv_re), .raddr(pv_ra), .rdata(pv_rd)
	);

	// decode of the captured request
	logic [bba_pkg::SIZE_W:0]    total;
	logic                        zero_size, too_big, found, pool_full, free_bad;
	logic [LW-1:0]               want_d, found_lvl;
	logic [KW-1:0]               found_head;
	logic [bba_pkg::ADDR_W-1:0]  b_off;
	logic [UW-1:0]               u_dec, fresh_u;
	logic [31:0]                 limit_eff, handed_units, ub;

	always_comb begin
		total     = (bba_pkg::SIZE_W+1)'(size_q) + (bba_pkg::SIZE_W+1)'(bba_pkg::HEADER_BYTES);
		zero_size = (size_q == '0);
		too_big   = 1'b1;
		want_d    = '0;
		for (int i = bba_pkg::TOP_LEVEL; i >= 0; i--) begin
			if (32'(total) <= (32'd1 << (i + bba_pkg::MIN_SHIFT))) begin
				too_big = 1'b0;
				want_d  = LW'(i);
			end
		end
		found      = 1'b0;
		found_lvl  = '0;
		found_head = bba_pkg::NIL;
		for (int i = bba_pkg::TOP_LEVEL; i >= 0; i--) begin
			if (32'(i) >= 32'(want_d) && heads_q[i] != bba_pkg::NIL) begin
				found      = 1'b1;
				found_lvl  = LW'(i);
				found_head = heads_q[i];
			end
		end
		limit_eff    = (32'(limit_q) < bba_pkg::NUM_PAGES) ? 32'(limit_q) : bba_pkg::NUM_PAGES;
		pool_full    = 32'(pages_q) >= limit_eff;
		handed_units = 32'(pages_q) * bba_pkg::UNITS_PER_PAGE;
		fresh_u      = UW'(handed_units);
		b_off        = addr_q - bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES);
		ub           = 32'(b_off) >> bba_pkg::MIN_SHIFT;
		u_dec        = UW'(ub);
		free_bad     = (32'(addr_q) < bba_pkg::HEADER_BYTES)
			|| (b_off[bba_pkg::MIN_SHIFT-1:0] != '0)
			|| (ub >= handed_units) || (ub >= bba_pkg::UNIT_COUNT);
	end

	// level arithmetic
	logic [LW-1:0] lm, hidx, lvf_rd;
	logic [UW-1:0] half_d, bud_d, merged_u;
	logic [KW-1:0] hsel;
	logic [UW:0]   merge_mask;

	always_comb begin
		lm         = l_q - LW'(1);
		hidx       = (cmd == bba_pkg::CMD_SPLIT_PUSH) ? lm : l_q;
		hsel       = heads_q[hidx];
		half_d     = u_q | (UW'(1) << lm);
		bud_d      = u_q ^ (UW'(1) << l_q);
		merge_mask = ((UW+1)'(1) << (32'(l_q) + 1)) - (UW+1)'(1);
		merged_u   = u_q & ~merge_mask[UW-1:0];
		lvf_rd     = bba_pkg::lv_fix(lv_rd);
	end

	always_comb begin
		st.is_free    = func_q;
		st.dec_err    = func_q ? free_bad : (zero_size || too_big || (!found && pool_full));
		st.dec_found  = found;
		st.free_taken = tk_rd;
		st.split_more = l_q > want_q;
		st.at_top     = 32'(l_q) == bba_pkg::TOP_LEVEL;
		st.bud_free   = !tk_rd && (lvf_rd == l_q);
		st.out_busy   = out_valid_q && !out_ready;
	end

	// RAM port steering, one access per port and cycle
	always_comb begin
		tk_we = 1'b0; tk_wa = '0; tk_wd = 1'b0; tk_re = 1'b0; tk_ra = '0;
		lv_we = 1'b0; lv_wa = '0; lv_wd = '0;   lv_re = 1'b0; lv_ra = '0;
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0;   nx_re = 1'b0; nx_ra = '0;
		pv_we = 1'b0; pv_wa = '0; pv_wd = '0;   pv_re = 1'b0; pv_ra = '0;
		case (cmd)
			bba_pkg::CMD_DECODE: begin
				tk_re = 1'b1; tk_ra = u_dec;
				lv_re = 1'b1; lv_ra = u_dec;
				nx_re = 1'b1; nx_ra = found_head[UW-1:0];
				pv_re = 1'b1; pv_ra = found_head[UW-1:0];
			end
			bba_pkg::CMD_UNLINK_HEAD1: begin
				pv_we = (nx_rd != bba_pkg::NIL); pv_wa = nx_rd[UW-1:0]; pv_wd = pv_rd;
				nx_we = 1'b1; nx_wa = u_q; nx_wd = bba_pkg::NIL;
			end
			bba_pkg::CMD_UNLINK_HEAD2: begin
				pv_we = 1'b1; pv_wa = u_q; pv_wd = bba_pkg::NIL;
			end
			bba_pkg::CMD_SPLIT_PUSH: begin
				lv_we = 1'b1; lv_wa = half_d; lv_wd = lm;
				tk_we = 1'b1; tk_wa = half_d; tk_wd = 1'b0;
				pv_we = 1'b1; pv_wa = half_d; pv_wd = bba_pkg::NIL;
				nx_we = 1'b1; nx_wa = half_d; nx_wd = hsel;
			end
			bba_pkg::CMD_PUSH_LINK: begin
				pv_we = (first_q != bba_pkg::NIL); pv_wa = first_q[UW-1:0];
				pv_wd = KW'(half_q);
			end
			bba_pkg::CMD_ALLOC_FIN: begin
				lv_we = 1'b1; lv_wa = u_q; lv_wd = want_q;
				tk_we = 1'b1; tk_wa = u_q; tk_wd = 1'b1;
			end
			bba_pkg::CMD_FREE_CHECK: begin
				tk_we = tk_rd; tk_wa = u_q; tk_wd = 1'b0;
			end
			bba_pkg::CMD_MERGE_READ: begin
				tk_re = 1'b1; tk_ra = bud_d;
				lv_re = 1'b1; lv_ra = bud_d;
				nx_re = 1'b1; nx_ra = bud_d;
				pv_re = 1'b1; pv_ra = bud_d;
			end
			bba_pkg::CMD_MERGE_UNLINK1: begin
				nx_we = (hsel != KW'(bud_q)) && (pv_rd != bba_pkg::NIL);
				nx_wa = pv_rd[UW-1:0]; nx_wd = nx_rd;
				pv_we = (nx_rd != bba_pkg::NIL); pv_wa = nx_rd[UW-1:0]; pv_wd = pv_rd;
			end
			bba_pkg::CMD_MERGE_UNLINK2: begin
				nx_we = 1'b1; nx_wa = bud_q; nx_wd = bba_pkg::NIL;
				pv_we = 1'b1; pv_wa = bud_q; pv_wd = bba_pkg::NIL;
				lv_we = 1'b1; lv_wa = merged_u; lv_wd = l_q + LW'(1);
				tk_we = 1'b1; tk_wa = merged_u; tk_wd = 1'b0;
			end
			bba_pkg::CMD_FREE_PUSH: begin
				pv_we = 1'b1; pv_wa = u_q; pv_wd = bba_pkg::NIL;
				nx_we = 1'b1; nx_wa = u_q; nx_wd = hsel;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bba_pkg::LEVEL_COUNT; i++) heads_q[i] <= bba_pkg::NIL;
			pages_q     <= '0;
			bytes_q     <= '0;
			limit_q     <= bba_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (cmd == bba_pkg::CMD_RESP) out_valid_q <= 1'b1;
			else if (out_ready)           out_valid_q <= 1'b0;
			case (cmd)
				bba_pkg::CMD_DECODE: begin
					if (!func_q && !zero_size && !too_big && !found && !pool_full) begin
						pages_q <= pages_q + bba_pkg::PAGE_W'(1);
					end
				end
				bba_pkg::CMD_UNLINK_HEAD1: heads_q[hidx] <= nx_rd;
				bba_pkg::CMD_SPLIT_PUSH:   heads_q[hidx] <= KW'(half_d);
				bba_pkg::CMD_ALLOC_FIN:    bytes_q <= bytes_q + bba_pkg::blk_bytes(want_q);
				bba_pkg::CMD_FREE_CHECK: begin
					if (tk_rd) bytes_q <= bytes_q - bba_pkg::blk_bytes(lvf_rd);
				end
				bba_pkg::CMD_MERGE_UNLINK1: begin
					if (hsel == KW'(bud_q)) heads_q[hidx] <= nx_rd;
				end
				bba_pkg::CMD_FREE_PUSH: heads_q[hidx] <= KW'(u_q);
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd)
			bba_pkg::CMD_LOAD: begin
				func_q <= func;
				size_q <= alloc_size;
				addr_q <= block_address;
			end
			bba_pkg::CMD_DECODE: begin
				res_status_q <= bba_pkg::ST_OK;
				res_addr_q   <= '0;
				res_lvl_q    <= '0;
				want_q       <= want_d;
				if (func_q) begin
					u_q <= u_dec;
					if (free_bad) res_status_q <= bba_pkg::ST_IGNORED;
				end else if (zero_size) begin
					res_status_q <= bba_pkg::ST_ZERO;
				end else if (too_big) begin
					res_status_q <= bba_pkg::ST_BIG;
				end else if (found) begin
					u_q <= found_head[UW-1:0];
					l_q <= found_lvl;
				end else if (pool_full) begin
					res_status_q <= bba_pkg::ST_FULL;
				end else begin
					u_q <= fresh_u;
					l_q <= LW'(bba_pkg::TOP_LEVEL);
				end
			end
			bba_pkg::CMD_SPLIT_PUSH: begin
				first_q <= hsel;
				half_q  <= half_d;
				l_q     <= lm;
			end
			bba_pkg::CMD_ALLOC_FIN: begin
				res_status_q <= bba_pkg::ST_OK;
				res_addr_q   <= bba_pkg::ADDR_W'((32'(u_q) << bba_pkg::MIN_SHIFT)
					+ bba_pkg::HEADER_BYTES);
				res_lvl_q    <= want_q;
			end
			bba_pkg::CMD_FREE_CHECK: begin
				if (tk_rd) begin
					l_q       <= lvf_rd;
					res_lvl_q <= lvf_rd;
				end else begin
					res_status_q <= bba_pkg::ST_IGNORED;
				end
			end
			bba_pkg::CMD_MERGE_READ: bud_q <= bud_d;
			bba_pkg::CMD_MERGE_UNLINK2: begin
				u_q <= merged_u;
				l_q <= l_q + LW'(1);
			end
			bba_pkg::CMD_FREE_PUSH: begin
				first_q <= hsel;
				half_q  <= u_q;
			end
			bba_pkg::CMD_RESP: begin
				out_status_q <= res_status_q;
				out_addr_q   <= res_addr_q;
				out_lvl_q    <= res_lvl_q;
				out_bytes_q  <= bytes_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign user_address = out_addr_q;
	assign block_level  = bba_pkg::OUT_LVL_W'(out_lvl_q);
	assign bytes_given  = out_bytes_q;

	a_resp_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == bba_pkg::CMD_RESP) |-> (!out_valid_q || out_ready))
		else $error("result overwritten while still waiting");

	a_split_above_want: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == bba_pkg::CMD_SPLIT_PUSH) |-> (l_q > want_q))
		else $error("split below the wanted level");

	a_pages_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pages_q != $past(pages_q)) |-> (pages_q == $past(pages_q) + bba_pkg::PAGE_W'(1)))
		else $error("page count moved by more than one");

endmodule

`default_nettype wire

// ===== rtl/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: sequencer plus datapath.
// Depends on bba_pkg, bba_ctrl, bba_datapath and bba_ram.
//
// Usage: a request (func, alloc_size, block_address) is taken on the
// in_valid/in_ready handshake; one result (status, user_address,
// block_level, bytes_given) leaves on out_valid/out_ready for every
// request. in_ready is high only while the sequencer is idle, so one
// request is worked on at a time.
// A request rejected at decode goes straight to its result, as does a free
// of a block not taken. An allocate unlinks a free list head when one is
// found, else takes a fresh page, then splits one level at a time down to
// the wanted level. A free merges the block with its buddy while the buddy
// is a free block of its level and the top is not reached, then pushes it
// on its free list. in_ready returns the cycle after the result is loaded.
// The user must write page_limit through cfg_we/cfg_wdata only while idle;
// the block itself does not enforce it. Reset clears list heads, counters
// and page_limit (to 16); the header RAMs are not cleared, so a free of an
// address inside a block may read an entry that was never written.
// If the receiver stalls, the result holds in the output register; the
// next request may be accepted but its result waits for the slot to drain.
`timescale 1ns / 1ps
`default_nettype none

module buddy_block_allocator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            func,
	input  wire logic [bba_pkg::SIZE_W-1:0]      alloc_size,
	input  wire logic [bba_pkg::ADDR_W-1:0]      block_address,
	input  wire logic                            cfg_we,
	input  wire logic [bba_pkg::LIMIT_W-1:0]     cfg_wdata,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [bba_pkg::STATUS_W-1:0]    status,
	output logic      [bba_pkg::ADDR_W-1:0]      user_address,
	output logic      [bba_pkg::OUT_LVL_W-1:0]   block_level,
	output logic      [bba_pkg::BYTES_W-1:0]     bytes_given
);

	// command and status between sequencer and datapath
	bba_pkg::cmd_t       cmd;
	bba_pkg::dp_status_t dp_st;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (dp_st),
		.cmd      (cmd)
	);

	// hold the request, walk lists and headers, drive the result register
	bba_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (dp_st),
		.func          (func),
		.alloc_size    (alloc_size),
		.block_address (block_address),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.user_address  (user_address),
		.block_level   (block_level),
		.bytes_given   (bytes_given)
	);

endmodule

`default_nettype wire
